>>> hw/rtl/row_vector_normalizer_core_defines.svh
// Assertion macros for the row vector normaliser.
`ifndef ROW_VECTOR_NORMALIZER_CORE_DEFINES_SVH
`define ROW_VECTOR_NORMALIZER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define RVN_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RVN_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define RVN_ASSERT(label, clk, rst_n, prop, msg)
`define RVN_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

>>> hw/rtl/rvn_pkg.sv
// Shared constants and command/status types for the row vector normaliser.
package rvn_pkg;
    localparam int RowCapacity  = 64;
    localparam int SampleWidth  = 16;
    localparam int FractionBits = 16;
    localparam int SqrtFrac     = 8;
    localparam int CountWidth   = $clog2(RowCapacity + 1);
    localparam int AddrWidth    = $clog2(RowCapacity);
    localparam int AbsWidth     = SampleWidth + CountWidth - 1;
    localparam int SqWidth      = 2 * SampleWidth + CountWidth - 2;
    // Radicand of the L2 root carries 2*SqrtFrac fraction bits; padded to even.
    localparam int RadWidth     = ((SqWidth + 2 * SqrtFrac + 1) / 2) * 2;
    localparam int RootWidth    = RadWidth / 2;
    // Dividend mag << (F + 8), the largest shift needed.
    localparam int NumWidth     = SampleWidth + FractionBits + SqrtFrac;
    localparam int DenWidth     = (RootWidth > AbsWidth) ? RootWidth : AbsWidth;
    localparam int QuoWidth     = NumWidth;

    localparam logic [1:0] MODE_MAX = 2'd0;
    localparam logic [1:0] MODE_L1  = 2'd1;
    localparam logic [1:0] MODE_L2  = 2'd2;

    typedef struct packed {
        logic load;        // store and accumulate the input sample
        logic sqrt_start;  // start the root of the square sum
        logic sqrt_step;   // one root iteration
        logic pick_den;    // latch divisor for the mode
        logic rd_start;    // read row entry at rd index, start division
        logic div_step;    // one division iteration
        logic finish;      // form the result into the output register
        logic clear_row;   // clear the row accumulators
    } rvn_cmd_t;

    typedef struct packed {
        logic [CountWidth-1:0] fill;
        logic                  full;
        logic                  sqrt_done;
        logic                  div_done;
        logic                  den_zero;
    } rvn_status_t;
endpackage

>>> hw/rtl/row_vector_normalizer_core.sv
// Top level of the row vector normaliser.
// Input channel in_valid/in_ready carries one signed sample per item with
// row_end marking the last item of a row. Samples load at one per cycle.
// After the row_end item the block is busy: the L2 root runs one bit per
// cycle (always run, whatever the mode), then each stored sample takes a
// store read, a start state, a restoring division of one quotient bit per
// cycle (40 steps and a final check of the step count; the division is cut
// short when the divisor is zero) and a state to form the result. in_ready
// is low until the whole row has been emitted; samples beyond 64 are dropped
// and overflow_flag is set on every result of that row. Output channel
// out_valid/out_ready carries norm_value (Q15.16), out_last and
// overflow_flag; a stalled receiver holds the result register and the block
// waits before the next division result.
// norm_mode is written through cfg_we/cfg_data, sampled at the divisor pick.
// Reset clears the row accumulators and sets norm_mode to the maximum mode;
// the row store needs no clearing.
module row_vector_normalizer_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] sample,
    input  logic               row_end,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] norm_value,
    output logic               out_last,
    output logic               overflow_flag
);
    rvn_pkg::rvn_cmd_t    cmd;
    rvn_pkg::rvn_status_t status;
    logic [rvn_pkg::AddrWidth-1:0] rd_idx;
    logic [1:0] mode_reg;
    logic [31:0] result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= rvn_pkg::MODE_MAX;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_data;
        end
    end

    rvn_controller u_ctrl
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .row_end(row_end),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_last(out_last), .overflow_flag(overflow_flag),
        .status(status), .cmd(cmd), .rd_idx(rd_idx)
    );

    rvn_datapath u_dp
    (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .rd_idx(rd_idx),
        .mode(mode_reg), .sample(sample), .status(status), .result(result)
    );

    assign norm_value = result;
endmodule

>>> hw/rtl/rvn_datapath.sv
// Row store, accumulators, shared root and division units of the normaliser.
`include "row_vector_normalizer_core_defines.svh"
module rvn_datapath
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  rvn_pkg::rvn_cmd_t                     cmd,
    input  logic [rvn_pkg::AddrWidth-1:0]         rd_idx,
    input  logic [1:0]                            mode,
    input  logic signed [rvn_pkg::SampleWidth-1:0] sample,
    output rvn_pkg::rvn_status_t                  status,
    output logic [31:0]                           result
);
    localparam int SW = rvn_pkg::SampleWidth;
    localparam int NW = rvn_pkg::NumWidth;
    localparam int DW = rvn_pkg::DenWidth;
    localparam int RW = rvn_pkg::RadWidth;
    localparam int TW = rvn_pkg::RootWidth;

    logic signed [SW-1:0] store_mem [rvn_pkg::RowCapacity];
    logic signed [SW-1:0] rd_data_reg;

    logic [rvn_pkg::CountWidth-1:0] fill_reg, fill_next;
    logic signed [SW-1:0]           max_reg, max_next;
    logic [rvn_pkg::AbsWidth-1:0]   abs_reg, abs_next;
    logic [rvn_pkg::SqWidth-1:0]    sq_reg, sq_next;

    logic [SW-1:0]   in_mag;
    logic [2*SW-1:0] in_sq;

    always_comb
    begin
        in_mag = sample[SW-1] ? SW'(-sample) : SW'(sample);
        in_sq  = in_mag * in_mag;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && !status.full)
        begin
            store_mem[fill_reg[rvn_pkg::AddrWidth-1:0]] <= sample;
        end
        rd_data_reg <= store_mem[rd_idx];
    end

    always_comb
    begin
        fill_next = fill_reg;
        max_next  = max_reg;
        abs_next  = abs_reg;
        sq_next   = sq_reg;
        if (cmd.clear_row)
        begin
            fill_next = '0;
            max_next  = {1'b1, {(SW-1){1'b0}}};
            abs_next  = '0;
            sq_next   = '0;
        end
        else if (cmd.load && !status.full)
        begin
            fill_next = fill_reg + 1'b1;
            if (sample > max_reg)
            begin
                max_next = sample;
            end
            abs_next = abs_reg + rvn_pkg::AbsWidth'(in_mag);
            sq_next  = sq_reg + rvn_pkg::SqWidth'(in_sq);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            max_reg  <= {1'b1, {(SW-1){1'b0}}};
            abs_reg  <= '0;
            sq_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            max_reg  <= max_next;
            abs_reg  <= abs_next;
            sq_reg   <= sq_next;
        end
    end

    // Bitwise square root, two radicand bits per step.
    logic [RW-1:0] rad_reg;
    logic [TW+1:0] rem_reg;
    logic [TW-1:0] root_reg;
    logic [$clog2(TW+1)-1:0] sq_cnt_reg;
    logic [TW+1:0] trial;

    always_comb
    begin
        trial = {rem_reg[TW-1:0], rad_reg[RW-1 -: 2]} - {root_reg, 2'b01};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_cnt_reg <= '0;
        end
        else if (cmd.sqrt_start)
        begin
            sq_cnt_reg <= ($clog2(TW+1))'(TW);
        end
        else if (cmd.sqrt_step && sq_cnt_reg != '0)
        begin
            sq_cnt_reg <= sq_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_start)
        begin
            rad_reg  <= RW'({sq_reg, {(2*rvn_pkg::SqrtFrac){1'b0}}});
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.sqrt_step && sq_cnt_reg != '0)
        begin
            rad_reg <= {rad_reg[RW-3:0], 2'b00};
            if (!trial[TW+1])
            begin
                rem_reg  <= trial;
                root_reg <= {root_reg[TW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= {rem_reg[TW-1:0], rad_reg[RW-1 -: 2]};
                root_reg <= {root_reg[TW-2:0], 1'b0};
            end
        end
    end

    // Divisor selection.
    logic [DW-1:0] den_reg;
    logic          den_neg_reg;
    logic          l2_reg;
    logic [SW-1:0] max_mag;

    always_comb
    begin
        max_mag = max_reg[SW-1] ? SW'(-max_reg) : SW'(max_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pick_den)
        begin
            unique case (mode)
                rvn_pkg::MODE_L1:
                begin
                    den_reg     <= DW'(abs_reg);
                    den_neg_reg <= 1'b0;
                    l2_reg      <= 1'b0;
                end
                rvn_pkg::MODE_L2:
                begin
                    den_reg     <= DW'(root_reg);
                    den_neg_reg <= 1'b0;
                    l2_reg      <= 1'b1;
                end
                default:
                begin
                    den_reg     <= DW'(max_mag);
                    den_neg_reg <= max_reg[SW-1];
                    l2_reg      <= 1'b0;
                end
            endcase
        end
    end

    // Restoring divider, one quotient bit per step.
    logic [NW-1:0]   num_reg;
    logic [DW:0]     drem_reg;
    logic [NW-1:0]   quo_reg;
    logic [$clog2(NW+1)-1:0] dv_cnt_reg;
    logic            neg_reg;
    logic [SW-1:0]   s_mag;
    logic [DW+1:0]   dshift;
    logic [DW+1:0]   dsub;

    always_comb
    begin
        s_mag  = rd_data_reg[SW-1] ? SW'(-rd_data_reg) : SW'(rd_data_reg);
        dshift = {drem_reg, num_reg[NW-1]};
        dsub   = dshift - {2'b00, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_cnt_reg <= '0;
        end
        else if (cmd.rd_start)
        begin
            dv_cnt_reg <= ($clog2(NW+1))'(NW);
        end
        else if (cmd.div_step && dv_cnt_reg != '0)
        begin
            dv_cnt_reg <= dv_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_start)
        begin
            num_reg  <= l2_reg
                ? NW'({s_mag, {(rvn_pkg::FractionBits + rvn_pkg::SqrtFrac){1'b0}}})
                : NW'({s_mag, {rvn_pkg::FractionBits{1'b0}}});
            drem_reg <= '0;
            quo_reg  <= '0;
            neg_reg  <= rd_data_reg[SW-1];
        end
        else if (cmd.div_step && dv_cnt_reg != '0)
        begin
            num_reg <= {num_reg[NW-2:0], 1'b0};
            if (!dsub[DW+1])
            begin
                drem_reg <= dsub[DW:0];
                quo_reg  <= {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                drem_reg <= dshift[DW:0];
                quo_reg  <= {quo_reg[NW-2:0], 1'b0};
            end
        end
    end

    // Rounding, sign and saturation.
    logic [NW:0]   q_rnd;
    logic [NW:0]   mag_pick;
    logic          neg_pick;
    logic [31:0]   res_next;
    logic [31:0]   result_reg;
    logic [NW+1:0] rem2;

    always_comb
    begin
        rem2  = {{(NW-DW){1'b0}}, drem_reg, 1'b0};
        q_rnd = {1'b0, quo_reg};
        if (rem2 >= (NW+2)'(den_reg))
        begin
            q_rnd = {1'b0, quo_reg} + 1'b1;
        end
        if (den_reg == '0)
        begin
            mag_pick = (NW+1)'({s_mag, {rvn_pkg::FractionBits{1'b0}}});
            neg_pick = neg_reg;
        end
        else
        begin
            mag_pick = q_rnd;
            neg_pick = (neg_reg != den_neg_reg) && (q_rnd != '0);
        end
        if (neg_pick)
        begin
            if (mag_pick >= (NW+1)'(33'h0_8000_0000))
            begin
                res_next = 32'h8000_0000;
            end
            else
            begin
                res_next = 32'(-mag_pick);
            end
        end
        else if (mag_pick > (NW+1)'(33'h0_7FFF_FFFF))
        begin
            res_next = 32'h7FFF_FFFF;
        end
        else
        begin
            res_next = mag_pick[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            result_reg <= res_next;
        end
    end

    assign result           = result_reg;
    assign status.fill      = fill_reg;
    assign status.full      = (fill_reg == rvn_pkg::CountWidth'(rvn_pkg::RowCapacity));
    assign status.sqrt_done = (sq_cnt_reg == '0);
    assign status.div_done  = (dv_cnt_reg == '0);
    assign status.den_zero  = (den_reg == '0);

    `RVN_ASSERT(a_fill_bound, clk, rst_n,
        fill_reg <= rvn_pkg::CountWidth'(rvn_pkg::RowCapacity), "fill count beyond capacity")
    `RVN_ASSERT_NEXT(a_clear_max, clk, rst_n, cmd.clear_row,
        fill_reg == '0 && abs_reg == '0 && sq_reg == '0, "row state not cleared")
    `RVN_ASSERT_NEXT(a_sqrt_start, clk, rst_n, cmd.sqrt_start,
        sq_cnt_reg == ($clog2(TW+1))'(TW), "root unit not started")
endmodule

>>> hw/rtl/rvn_controller.sv
// Sequencing state machine of the row vector normaliser.
`include "row_vector_normalizer_core_defines.svh"
module rvn_controller
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          row_end,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_last,
    output logic                          overflow_flag,
    input  rvn_pkg::rvn_status_t          status,
    output rvn_pkg::rvn_cmd_t             cmd,
    output logic [rvn_pkg::AddrWidth-1:0] rd_idx
);
    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_SQRT  = 3'd1;
    localparam logic [2:0] S_PICK  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_START = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [rvn_pkg::CountWidth-1:0] idx_reg, idx_next;
    logic drop_reg, drop_next;
    logic oflag_reg, oflag_next;
    logic valid_reg, valid_next;
    logic last_reg, last_next;
    logic accept;
    logic is_last;

    assign in_ready = (state_reg == S_LOAD);
    assign accept   = in_valid && in_ready;
    assign is_last  = (idx_reg + 1'b1 == status.fill);
    assign rd_idx   = idx_reg[rvn_pkg::AddrWidth-1:0];

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        drop_next  = drop_reg;
        oflag_next = oflag_reg;
        valid_next = valid_reg;
        last_next  = last_reg;
        cmd        = '0;
        if (valid_reg && out_ready)
        begin
            valid_next = 1'b0;
        end
        unique case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    if (status.full)
                    begin
                        drop_next = 1'b1;
                    end
                    if (row_end)
                    begin
                        state_next = S_SQRT;
                    end
                end
            end
            S_SQRT:
            begin
                cmd.sqrt_start = 1'b1;
                state_next     = S_PICK;
            end
            S_PICK:
            begin
                cmd.sqrt_step = 1'b1;
                if (status.sqrt_done)
                begin
                    cmd.pick_den = 1'b1;
                    idx_next     = '0;
                    state_next   = (status.fill == '0) ? S_LOAD : S_READ;
                    if (status.fill == '0)
                    begin
                        cmd.clear_row = 1'b1;
                        drop_next     = 1'b0;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_START;
            end
            S_START:
            begin
                cmd.rd_start = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done || status.den_zero)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!valid_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    valid_next = 1'b1;
                    last_next  = is_last;
                    oflag_next = drop_reg;
                    idx_next   = idx_reg + 1'b1;
                    if (is_last)
                    begin
                        cmd.clear_row = 1'b1;
                        drop_next     = 1'b0;
                        state_next    = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            idx_reg   <= '0;
            drop_reg  <= 1'b0;
            oflag_reg <= 1'b0;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            drop_reg  <= drop_next;
            oflag_reg <= oflag_next;
            valid_reg <= valid_next;
            last_reg  <= last_next;
        end
    end

    assign out_valid     = valid_reg;
    assign out_last      = last_reg;
    assign overflow_flag = oflag_reg;

    `RVN_ASSERT_NEXT(a_out_hold, clk, rst_n, valid_reg && !out_ready,
        valid_reg && $stable(last_reg), "stalled result changed")
    `RVN_ASSERT(a_no_load_busy, clk, rst_n, !(cmd.load && state_reg != S_LOAD),
        "sample loaded while busy")
    `RVN_ASSERT_NEXT(a_last_returns, clk, rst_n, cmd.finish && is_last,
        state_reg == S_LOAD, "row did not close")
endmodule

>>> test/row_vector_normalizer_core_tb.sv
// Self-checking testbench for the row vector normaliser: driver, monitor and predictor.
`timescale 1ns / 100ps

module row_vector_normalizer_core_tb;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int CycleLimit = 3000000;
    localparam int DrainCycles = 120;

    typedef struct {
        logic signed [15:0] smp;
        logic               last;
    } sample_item_t;

    typedef struct {
        logic signed [31:0] value;
        logic               last;
        logic               ovf;
    } norm_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_data = 2'd0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [15:0] sample = '0;
    logic               row_end = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] norm_value;
    logic               out_last;
    logic               overflow_flag;

    sample_item_t pending_samples[$];
    norm_result_t expected_norms[$];

    // Predictor state.
    logic signed [15:0] row_mem[rvn_pkg::RowCapacity];
    int                 row_fill;
    int                 row_max;
    longint unsigned    row_abs_sum;
    longint unsigned    row_sq_sum;
    bit                 row_dropped;
    logic [1:0]         active_mode;

    int send_idle;
    int recv_idle;
    int mismatches;
    int samples_sent;
    int results_seen;
    int rows_closed;
    int overflow_rows;
    int hold_left;
    bit hold_go;
    bit hold_used;
    int cycles;

    row_vector_normalizer_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample       (sample),
        .row_end      (row_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .norm_value   (norm_value),
        .out_last     (out_last),
        .overflow_flag(overflow_flag)
    );

    always #5 clk = ~clk;

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] clamp_q16(bit neg, longint unsigned mag);
        if (neg)
            return (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-mag);
        return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(mag);
    endfunction

    function automatic void clear_row_state();
        row_fill = 0;
        row_max = -32768;
        row_abs_sum = 0;
        row_sq_sum = 0;
        row_dropped = 0;
    endfunction

    // Accumulate one accepted sample and, on the row end, queue the whole row's results.
    function automatic void predict_norms(logic signed [15:0] s, logic last);
        longint unsigned mag;
        longint unsigned den;
        longint unsigned q;
        longint unsigned r;
        int shift;
        bit den_neg;
        bit neg;
        norm_result_t res;
        if (row_fill < rvn_pkg::RowCapacity)
        begin
            mag = (s < 0) ? longint'(-int'(s)) : longint'(s);
            row_mem[row_fill] = s;
            row_fill++;
            if (int'(s) > row_max)
                row_max = s;
            row_abs_sum += mag;
            row_sq_sum += mag * mag;
        end
        else
            row_dropped = 1;
        if (!last)
            return;
        shift = 0;
        den_neg = 0;
        if (active_mode == rvn_pkg::MODE_L1)
            den = row_abs_sum;
        else if (active_mode == rvn_pkg::MODE_L2)
        begin
            den = root_floor(row_sq_sum << 16);
            shift = rvn_pkg::SqrtFrac;
        end
        else
        begin
            den = (row_max < 0) ? longint'(-row_max) : longint'(row_max);
            den_neg = row_max < 0;
        end
        rows_closed++;
        if (row_dropped)
            overflow_rows++;
        for (int i = 0; i < row_fill; i++)
        begin
            neg = row_mem[i] < 0;
            mag = neg ? longint'(-int'(row_mem[i])) : longint'(row_mem[i]);
            if (den == 0)
                res.value = clamp_q16(neg, mag << rvn_pkg::FractionBits);
            else
            begin
                q = (mag << (rvn_pkg::FractionBits + shift)) / den;
                r = (mag << (rvn_pkg::FractionBits + shift)) % den;
                if (r >= den - r)
                    q++;
                res.value = clamp_q16((neg != den_neg) && q != 0, q);
            end
            res.last = (i + 1 == row_fill);
            res.ovf = row_dropped;
            expected_norms.push_back(res);
        end
        clear_row_state();
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : sample_driver
        bit busy;
        sample_item_t it;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            sample <= '0;
            row_end <= 1'b0;
        end
        else
        begin
            busy = in_valid;
            if (in_valid && in_ready)
            begin
                predict_norms(sample, row_end);
                samples_sent++;
                busy = 0;
            end
            if (!busy)
            begin
                if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle)
                begin
                    it = pending_samples.pop_front();
                    in_valid <= 1'b1;
                    sample <= it.smp;
                    row_end <= it.last;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end
        else if (hold_go && !hold_used)
        begin
            hold_left <= 600;
            hold_used <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin : norm_monitor
        norm_result_t exp_res;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_norms.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected item: value %0d last %0b ovf %0b",
                                 norm_value, out_last, overflow_flag);
                end
                else
                begin
                    exp_res = expected_norms.pop_front();
                    if (norm_value !== exp_res.value || out_last !== exp_res.last
                        || overflow_flag !== exp_res.ovf)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                                     exp_res.value, exp_res.last, exp_res.ovf,
                                     norm_value, out_last, overflow_flag);
                    end
                end
            end
            out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("** row_vector_normalizer_core: FAILED **");
            $finish;
        end
    end

    task automatic push_sample(logic signed [15:0] s, logic last);
        sample_item_t it;
        it.smp = s;
        it.last = last;
        pending_samples.push_back(it);
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'($urandom_range(0, 40)) - 16'sd20;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_row(int len);
        for (int i = 0; i < len; i++)
            push_sample(rand_sample(), i == len - 1);
    endtask

    // Wait until every queued item is accepted and every result has come back.
    task automatic drain();
        while (pending_samples.size() > 0 || in_valid || expected_norms.size() > 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic set_mode(logic [1:0] m);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        active_mode = m;
    endtask

    int len;

    initial
    begin
        clear_row_state();
        active_mode = rvn_pkg::MODE_MAX;
        send_idle = 29;
        recv_idle = 52;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Maximum mode: extremes, a negative maximum and a zero maximum.
        push_sample(16'sh7FFF, 1'b0);
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sd1, 1'b1);
        push_sample(-16'sd5, 1'b0);
        push_sample(16'sh8000, 1'b1);
        push_sample(16'sd0, 1'b0);
        push_sample(-16'sd7, 1'b1);
        push_sample(16'sd3, 1'b1);
        drain();

        // Sum of magnitudes, with an all-zero row that passes samples through.
        set_mode(rvn_pkg::MODE_L1);
        push_sample(16'sd0, 1'b0);
        push_sample(16'sd0, 1'b1);
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sd1, 1'b1);
        drain();

        // Euclidean norm, and the unused code which acts as maximum.
        set_mode(rvn_pkg::MODE_L2);
        push_sample(16'sh7FFF, 1'b0);
        push_sample(-16'sd3, 1'b0);
        push_sample(16'sd4, 1'b1);
        drain();
        set_mode(MODE_SPARE);
        push_sample(-16'sd100, 1'b0);
        push_sample(-16'sd2, 1'b1);
        drain();

        // Mode changes part way through a row; only the value at the row end counts.
        push_sample(16'sd9, 1'b0);
        push_sample(-16'sd12, 1'b0);
        drain();
        set_mode(rvn_pkg::MODE_L1);
        push_sample(16'sd6, 1'b1);
        drain();

        // An overrun row, closed by a dropped sample, with the receiver held off
        // while a further row waits at the input.
        set_mode(rvn_pkg::MODE_L2);
        hold_go = 1'b1;
        push_row(rvn_pkg::RowCapacity + 3);
        push_row(5);
        drain();

        // Random rows, mostly short, cycling through the idle schemes.
        for (int ph = 0; ph < 6; ph++)
        begin
            set_mode(ph % 4 == 0 ? rvn_pkg::MODE_MAX : ph % 4 == 1 ? rvn_pkg::MODE_L1 :
                     ph % 4 == 2 ? rvn_pkg::MODE_L2 : MODE_SPARE);
            send_idle = (ph < 2) ? 29 : (ph < 4) ? 52 : 0;
            recv_idle = (ph < 2) ? 52 : (ph < 4) ? 29 : 0;
            for (int n = 0; n < 25; )
            begin
                case ($urandom_range(19))
                    0: len = $urandom_range(40, rvn_pkg::RowCapacity + 4);
                    1, 2, 3: len = $urandom_range(9, 20);
                    default: len = $urandom_range(1, 8);
                endcase
                push_row(len);
                n += len;
            end
            drain();
        end

        $display("Covered %0d samples in %0d rows (%0d overrun), %0d results checked,",
                 samples_sent, rows_closed, overflow_rows, results_seen);
        $display("over all four mode codes with sender and receiver idling and a long stall.");
        if (mismatches == 0 && expected_norms.size() == 0)
            $display("** row_vector_normalizer_core: PASSED **");
        else
            $display("** row_vector_normalizer_core: FAILED **");
        $finish;
    end
endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/rvn_pkg.sv
hw/rtl/rvn_datapath.sv
hw/rtl/rvn_controller.sv
hw/rtl/row_vector_normalizer_core.sv
test/row_vector_normalizer_core_tb.sv
